// ----- hdl/spl_pkg.sv -----
// Shared constants and saturating Q24.24 helpers for the source positivity limiter.
package spl_pkg;

    localparam int VW          = 48;
    localparam int FRAC        = 24;
    localparam int OPW         = VW + 1;
    localparam int PRODW       = 2 * VW;
    localparam int DIVW        = 72;
    localparam int THW         = FRAC + 1;
    localparam int SPECIES_CNT = 3;
    localparam int CFGW        = 47;
    localparam int CFG_IDXW    = 3;

    localparam logic [CFG_IDXW-1:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_LIMIT_FRAC = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_YE_LOWER   = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_YE_UPPER   = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_RAD_EN     = 3'd4;
    localparam logic [CFG_IDXW-1:0] CFG_FLUID_EN   = 3'd5;
    localparam logic [CFG_IDXW-1:0] CFG_BARYON     = 3'd6;

    localparam logic [THW-1:0] ONE_Q = THW'(1) << FRAC;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            return s[VW] ? VMIN : VMAX;
        end
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            return s[VW] ? VMIN : VMAX;
        end
        return s[VW-1:0];
    endfunction

    // Turns an exact product magnitude into a saturated signed Q24.24 value.
    function automatic logic signed [VW-1:0] q_format(input logic [PRODW-1:0] p,
                                                      input logic neg);
        logic        over;
        logic [63:0] r;
        over = |p[PRODW-1:FRAC+64];
        r    = p[FRAC+63:FRAC];
        if (neg) begin
            if (over || r > (64'(1) << (VW-1))) begin
                return VMIN;
            end
            return VW'(64'(0) - r);
        end
        if (over || r > 64'(VMAX)) begin
            return VMAX;
        end
        return VW'(r);
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
        return a[VW-1] ? VW'(-a) : a;
    endfunction

    function automatic logic [VW-1:0] pos_part(input logic signed [VW-1:0] a);
        return a[VW-1] ? '0 : a;
    endfunction

endpackage

// ----- hdl/spl_mul.sv -----
// Shift and add multiplier that forms an exact signed product one bit per cycle.
module spl_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [spl_pkg::OPW-1:0]  i_a,
    input  logic signed [spl_pkg::OPW-1:0]  i_b,
    output logic                            o_done,
    output logic [spl_pkg::PRODW-1:0]       o_prod,
    output logic                            o_neg
);
    localparam int CW = $clog2(spl_pkg::VW);

    logic                    r_busy;
    logic [CW-1:0]           r_cnt;
    logic [spl_pkg::VW-1:0]  r_a;
    logic [spl_pkg::VW-1:0]  r_hi;
    logic [spl_pkg::VW-1:0]  r_lo;
    logic                    r_neg;
    logic                    r_done;
    logic [spl_pkg::VW:0]    n_sum;
    logic [spl_pkg::OPW-1:0] n_ma;
    logic [spl_pkg::OPW-1:0] n_mb;

    assign n_ma  = i_a[spl_pkg::OPW-1] ? spl_pkg::OPW'(-i_a) : i_a;
    assign n_mb  = i_b[spl_pkg::OPW-1] ? spl_pkg::OPW'(-i_b) : i_b;
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(spl_pkg::VW - 1);
                r_a    <= n_ma[spl_pkg::VW-1:0];
                r_lo   <= n_mb[spl_pkg::VW-1:0];
                r_hi   <= '0;
                r_neg  <= i_a[spl_pkg::OPW-1] ^ i_b[spl_pkg::OPW-1];
            end else if (r_busy) begin
                r_hi <= n_sum[spl_pkg::VW:1];
                r_lo <= {n_sum[0], r_lo[spl_pkg::VW-1:1]};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
    assign o_neg  = r_neg;
endmodule

// ----- hdl/spl_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module spl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [spl_pkg::DIVW-1:0]    i_dividend,
    input  logic [spl_pkg::VW-1:0]      i_divisor,
    output logic                        o_done,
    output logic [spl_pkg::DIVW-1:0]    o_quot
);
    localparam int CW = $clog2(spl_pkg::DIVW);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [spl_pkg::DIVW-1:0]  r_q;
    logic [spl_pkg::VW-1:0]    r_rem;
    logic [spl_pkg::VW-1:0]    r_den;
    logic [spl_pkg::VW:0]      n_t;
    logic [spl_pkg::VW:0]      n_d;
    logic                      n_ge;

    assign n_t  = {r_rem, r_q[spl_pkg::DIVW-1]};
    assign n_ge = n_t >= {1'b0, r_den};
    assign n_d  = n_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(spl_pkg::DIVW - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_d[spl_pkg::VW-1:0] : n_t[spl_pkg::VW-1:0];
                r_q   <= {r_q[spl_pkg::DIVW-2:0], n_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- hdl/source_positivity_limiter_core.sv -----
// Top level: sequencer that runs the limiter on one shared multiplier and one shared divider.
// An active item runs its two predictions on the multiplier, then one multiplier pass and one
// divider pass for each limit ratio, and one multiplier pass for the Ye product.
// Throughput: one item at a time; a new item is taken only when the sequencer is idle.
// A finished result waits in the output register while the next item is accepted.
// Reset is synchronous and active low; it restores the register defaults and a fresh cell.
module source_positivity_limiter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cell_active, energy_prev, energy_incr, energy_curr, number_prev, number_incr,
    // number_curr, fluid_tau, conserved_density, electron_fraction, zero fill
    input  logic [415:0]                  s_axis_tdata,
    // species_index
    input  logic [1:0]                    s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // theta_out, zero fill
    output logic [31:0]                   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [spl_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  logic [spl_pkg::CFGW-1:0]      i_cfg_data
);
    localparam int VW  = spl_pkg::VW;
    localparam int OPW = spl_pkg::OPW;

    typedef enum logic [3:0] {
        S_IDLE, S_EMUL, S_NMUL, S_CHKE, S_CHKN, S_SUMS, S_YEMUL, S_FIN,
        S_FTAU, S_FYE, S_FROOM, S_RMUL, S_RDIV, S_OUT
    } t_state;

    t_state r_state, r_ret;

    logic [46:0] r_dt, r_bm;
    logic [24:0] r_lf, r_yl, r_yu;
    logic        r_rad, r_fluid;

    logic                  r_act, r_last;
    logic [1:0]            r_spc;
    logic signed [VW-1:0]  r_ep, r_ei, r_ec, r_np, r_ni, r_nc, r_tau;
    logic [46:0]           r_dens;
    logic [24:0]           r_ye;
    logic signed [VW-1:0]  r_estar, r_nstar;
    logic [spl_pkg::THW-1:0] r_theta;
    logic signed [VW-1:0]  r_els, r_ycs;
    logic [VW-1:0]         r_rden;

    logic                  r_mstart, r_dstart;
    logic signed [OPW-1:0] r_ma, r_mb;
    logic                  r_ovalid;
    logic [spl_pkg::THW-1:0] r_odata;

    logic                  m_done, d_done, m_neg;
    logic [spl_pkg::PRODW-1:0] m_prod;
    logic [spl_pkg::DIVW-1:0]  d_quot;
    logic signed [VW-1:0]  n_q, n_de, n_dn;
    logic signed [25:0]    n_yup, n_ydn;

    assign n_q   = spl_pkg::q_format(m_prod, m_neg);
    assign n_de  = spl_pkg::sat_sub(r_ec, r_estar);
    assign n_dn  = spl_pkg::sat_sub(r_nc, r_nstar);
    assign n_yup = $signed({1'b0, r_yu}) - $signed({1'b0, r_ye});
    assign n_ydn = $signed({1'b0, r_ye}) - $signed({1'b0, r_yl});

    spl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (m_done),
        .o_prod  (m_prod),
        .o_neg   (m_neg)
    );

    spl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dstart ? m_prod[spl_pkg::DIVW-1:0] : '0),
        .i_divisor  (r_rden),
        .o_done     (d_done),
        .o_quot     (d_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= '0;
            r_lf     <= spl_pkg::ONE_Q;
            r_yl     <= '0;
            r_yu     <= spl_pkg::ONE_Q;
            r_rad    <= 1'b1;
            r_fluid  <= 1'b0;
            r_bm     <= 47'(spl_pkg::ONE_Q);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spl_pkg::CFG_TIME_STEP:  r_dt    <= i_cfg_data;
                spl_pkg::CFG_LIMIT_FRAC: r_lf    <= i_cfg_data[24:0];
                spl_pkg::CFG_YE_LOWER:   r_yl    <= i_cfg_data[24:0];
                spl_pkg::CFG_YE_UPPER:   r_yu    <= i_cfg_data[24:0];
                spl_pkg::CFG_RAD_EN:     r_rad   <= i_cfg_data[0];
                spl_pkg::CFG_FLUID_EN:   r_fluid <= i_cfg_data[0];
                spl_pkg::CFG_BARYON:     r_bm    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_theta  <= spl_pkg::ONE_Q;
            r_els    <= '0;
            r_ycs    <= '0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act  <= s_axis_tdata[0];
                        r_ep   <= s_axis_tdata[48:1];
                        r_ei   <= s_axis_tdata[96:49];
                        r_ec   <= s_axis_tdata[144:97];
                        r_np   <= s_axis_tdata[192:145];
                        r_ni   <= s_axis_tdata[240:193];
                        r_nc   <= s_axis_tdata[288:241];
                        r_tau  <= s_axis_tdata[336:289];
                        r_dens <= s_axis_tdata[383:337];
                        r_ye   <= s_axis_tdata[408:384];
                        r_spc  <= s_axis_tuser;
                        r_last <= s_axis_tlast;
                        if (s_axis_tdata[0]) begin
                            r_ma     <= {2'b00, r_dt};
                            r_mb     <= {s_axis_tdata[96], s_axis_tdata[96:49]};
                            r_mstart <= 1'b1;
                            r_state  <= S_EMUL;
                        end else if (s_axis_tlast) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_EMUL: begin
                    if (m_done) begin
                        r_estar  <= spl_pkg::sat_add(r_ep, n_q);
                        r_ma     <= {2'b00, r_dt};
                        r_mb     <= {r_ni[VW-1], r_ni};
                        r_mstart <= 1'b1;
                        r_state  <= S_NMUL;
                    end
                end
                S_NMUL: begin
                    if (m_done) begin
                        r_nstar <= spl_pkg::sat_add(r_np, n_q);
                        r_state <= S_CHKE;
                    end
                end
                S_CHKE: begin
                    if (r_rad && n_de[VW-1]) begin
                        r_rden   <= spl_pkg::mag(n_de);
                        r_ma     <= {24'd0, r_lf};
                        r_mb     <= {1'b0, spl_pkg::pos_part(r_estar)};
                        r_mstart <= 1'b1;
                        r_ret    <= S_CHKN;
                        r_state  <= S_RMUL;
                    end else begin
                        r_state <= S_CHKN;
                    end
                end
                S_CHKN: begin
                    if (r_rad && n_dn[VW-1]) begin
                        r_rden   <= spl_pkg::mag(n_dn);
                        r_ma     <= {24'd0, r_lf};
                        r_mb     <= {1'b0, spl_pkg::pos_part(r_nstar)};
                        r_mstart <= 1'b1;
                        r_ret    <= S_SUMS;
                        r_state  <= S_RMUL;
                    end else begin
                        r_state <= S_SUMS;
                    end
                end
                S_SUMS: begin
                    r_els <= spl_pkg::sat_sub(r_els, n_de);
                    if (spl_pkg::SPECIES_CNT == 3 && r_spc[1] == 1'b0) begin
                        r_ma     <= {2'b00, r_bm};
                        r_mb     <= {n_dn[VW-1], n_dn};
                        r_mstart <= 1'b1;
                        r_state  <= S_YEMUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_YEMUL: begin
                    if (m_done) begin
                        r_ycs   <= r_spc[0] ? spl_pkg::sat_add(r_ycs, n_q)
                                            : spl_pkg::sat_sub(r_ycs, n_q);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    priority if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_fluid) begin
                        r_state <= S_FTAU;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_FTAU: begin
                    if (r_els[VW-1]) begin
                        r_rden   <= spl_pkg::mag(r_els);
                        r_ma     <= {24'd0, r_lf};
                        r_mb     <= {1'b0, spl_pkg::pos_part(r_tau)};
                        r_mstart <= 1'b1;
                        r_ret    <= S_FYE;
                        r_state  <= S_RMUL;
                    end else begin
                        r_state <= S_FYE;
                    end
                end
                S_FYE: begin
                    priority if (r_ycs == '0) begin
                        r_state <= S_OUT;
                    end else if (!r_ycs[VW-1]) begin
                        r_ma     <= {2'b00, r_dens};
                        r_mb     <= OPW'(n_yup);
                        r_mstart <= 1'b1;
                        r_state  <= S_FROOM;
                    end else begin
                        r_ma     <= {2'b00, r_dens};
                        r_mb     <= OPW'(n_ydn);
                        r_mstart <= 1'b1;
                        r_state  <= S_FROOM;
                    end
                end
                S_FROOM: begin
                    if (m_done) begin
                        r_rden   <= spl_pkg::mag(r_ycs);
                        r_ma     <= {24'd0, r_lf};
                        r_mb     <= {1'b0, spl_pkg::pos_part(n_q)};
                        r_mstart <= 1'b1;
                        r_ret    <= S_OUT;
                        r_state  <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    if (m_done) begin
                        r_dstart <= 1'b1;
                        r_state  <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (d_done) begin
                        if (d_quot <= spl_pkg::DIVW'(r_theta)) begin
                            r_theta <= d_quot[spl_pkg::THW-1:0];
                        end
                        r_state <= r_ret;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_act ? r_theta : spl_pkg::ONE_Q;
                        r_theta  <= spl_pkg::ONE_Q;
                        r_els    <= '0;
                        r_ycs    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_odata};
endmodule

// ----- hdl/spl_chk.sv -----
// Port level checker for the source positivity limiter, bound to the top level.
module spl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tdata0,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:25] == 7'd0 && m_axis_tdata[24:0] <= 25'h1000000))
        else $error("theta item outside zero to one");

    a_busy_after_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata0) |=> !s_axis_tready)
        else $error("active item did not start the sequencer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result item changed");
endmodule

bind source_positivity_limiter_core spl_chk u_spl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata0 (s_axis_tdata[0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
